// ===== rtl/kmpm_pkg.sv =====
// kmpm_pkg: shared types and constants for the keyboard matrix port mapper
// host usage codes, matrix key positions, item op codes and the key event struct
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kmpm_pkg;

    // item op codes
    localparam logic OP_KEY_EVENT = 1'b0;
    localparam logic OP_PORT_READ = 1'b1;

    localparam int unsigned NUM_HOST_KEYS = 256;
    localparam int unsigned NUM_MKEYS     = 40;
    localparam int unsigned NUM_HROWS     = 8;
    localparam int unsigned HROW_KEYS     = 5;

    typedef logic [NUM_HOST_KEYS-1:0] t_key_map;
    typedef logic [NUM_MKEYS-1:0]     t_matrix;

    // one key down/up update of the host key bitmap
    typedef struct packed {
        logic       we;
        logic [7:0] code;
        logic       down;
    } t_key_event;

    // matrix key positions: four rows of ten, left to right
    localparam int unsigned MK_1   = 0;
    localparam int unsigned MK_2   = 1;
    localparam int unsigned MK_3   = 2;
    localparam int unsigned MK_4   = 3;
    localparam int unsigned MK_5   = 4;
    localparam int unsigned MK_6   = 5;
    localparam int unsigned MK_7   = 6;
    localparam int unsigned MK_8   = 7;
    localparam int unsigned MK_9   = 8;
    localparam int unsigned MK_0   = 9;
    localparam int unsigned MK_Q   = 10;
    localparam int unsigned MK_W   = 11;
    localparam int unsigned MK_E   = 12;
    localparam int unsigned MK_R   = 13;
    localparam int unsigned MK_T   = 14;
    localparam int unsigned MK_Y   = 15;
    localparam int unsigned MK_U   = 16;
    localparam int unsigned MK_I   = 17;
    localparam int unsigned MK_O   = 18;
    localparam int unsigned MK_P   = 19;
    localparam int unsigned MK_A   = 20;
    localparam int unsigned MK_S   = 21;
    localparam int unsigned MK_D   = 22;
    localparam int unsigned MK_F   = 23;
    localparam int unsigned MK_G   = 24;
    localparam int unsigned MK_H   = 25;
    localparam int unsigned MK_J   = 26;
    localparam int unsigned MK_K   = 27;
    localparam int unsigned MK_L   = 28;
    localparam int unsigned MK_ENT = 29;
    localparam int unsigned MK_CS  = 30;
    localparam int unsigned MK_Z   = 31;
    localparam int unsigned MK_X   = 32;
    localparam int unsigned MK_C   = 33;
    localparam int unsigned MK_V   = 34;
    localparam int unsigned MK_B   = 35;
    localparam int unsigned MK_N   = 36;
    localparam int unsigned MK_M   = 37;
    localparam int unsigned MK_SS  = 38;
    localparam int unsigned MK_SP  = 39;

    // host usage codes
    localparam logic [7:0] HU_A        = 8'd4;
    localparam logic [7:0] HU_B        = 8'd5;
    localparam logic [7:0] HU_C        = 8'd6;
    localparam logic [7:0] HU_D        = 8'd7;
    localparam logic [7:0] HU_E        = 8'd8;
    localparam logic [7:0] HU_F        = 8'd9;
    localparam logic [7:0] HU_G        = 8'd10;
    localparam logic [7:0] HU_H        = 8'd11;
    localparam logic [7:0] HU_I        = 8'd12;
    localparam logic [7:0] HU_J        = 8'd13;
    localparam logic [7:0] HU_K        = 8'd14;
    localparam logic [7:0] HU_L        = 8'd15;
    localparam logic [7:0] HU_M        = 8'd16;
    localparam logic [7:0] HU_N        = 8'd17;
    localparam logic [7:0] HU_O        = 8'd18;
    localparam logic [7:0] HU_P        = 8'd19;
    localparam logic [7:0] HU_Q        = 8'd20;
    localparam logic [7:0] HU_R        = 8'd21;
    localparam logic [7:0] HU_S        = 8'd22;
    localparam logic [7:0] HU_T        = 8'd23;
    localparam logic [7:0] HU_U        = 8'd24;
    localparam logic [7:0] HU_V        = 8'd25;
    localparam logic [7:0] HU_W        = 8'd26;
    localparam logic [7:0] HU_X        = 8'd27;
    localparam logic [7:0] HU_Y        = 8'd28;
    localparam logic [7:0] HU_Z        = 8'd29;
    localparam logic [7:0] HU_1        = 8'd30;
    localparam logic [7:0] HU_2        = 8'd31;
    localparam logic [7:0] HU_3        = 8'd32;
    localparam logic [7:0] HU_4        = 8'd33;
    localparam logic [7:0] HU_5        = 8'd34;
    localparam logic [7:0] HU_6        = 8'd35;
    localparam logic [7:0] HU_7        = 8'd36;
    localparam logic [7:0] HU_8        = 8'd37;
    localparam logic [7:0] HU_9        = 8'd38;
    localparam logic [7:0] HU_0        = 8'd39;
    localparam logic [7:0] HU_RET      = 8'd40;
    localparam logic [7:0] HU_ESC      = 8'd41;
    localparam logic [7:0] HU_BKSP     = 8'd42;
    localparam logic [7:0] HU_TAB      = 8'd43;
    localparam logic [7:0] HU_SPACE    = 8'd44;
    localparam logic [7:0] HU_MINUS    = 8'd45;
    localparam logic [7:0] HU_EQUALS   = 8'd46;
    localparam logic [7:0] HU_LBRK     = 8'd47;
    localparam logic [7:0] HU_RBRK     = 8'd48;
    localparam logic [7:0] HU_BSLASH   = 8'd49;
    localparam logic [7:0] HU_SEMI     = 8'd51;
    localparam logic [7:0] HU_APOS     = 8'd52;
    localparam logic [7:0] HU_GRAVE    = 8'd53;
    localparam logic [7:0] HU_COMMA    = 8'd54;
    localparam logic [7:0] HU_PERIOD   = 8'd55;
    localparam logic [7:0] HU_SLASH    = 8'd56;
    localparam logic [7:0] HU_CAPS     = 8'd57;
    localparam logic [7:0] HU_RIGHT    = 8'd79;
    localparam logic [7:0] HU_LEFT     = 8'd80;
    localparam logic [7:0] HU_DOWN     = 8'd81;
    localparam logic [7:0] HU_UP       = 8'd82;
    localparam logic [7:0] HU_NUBSLASH = 8'd100;
    localparam logic [7:0] HU_LSHIFT   = 8'd225;
    localparam logic [7:0] HU_LALT     = 8'd226;
    localparam logic [7:0] HU_RSHIFT   = 8'd229;
    localparam logic [7:0] HU_RALT     = 8'd230;

    // letters and digits occupy contiguous code ranges
    localparam int unsigned HU_LETTER_LO = 4;
    localparam int unsigned HU_LETTER_HI = 29;
    localparam int unsigned HU_DIGIT_LO  = 30;
    localparam int unsigned HU_DIGIT_HI  = 39;

    // host key that drives each matrix key in the positional layout
    localparam logic [7:0] DIRECT_CODE [NUM_MKEYS] = '{
        HU_1, HU_2, HU_3, HU_4, HU_5, HU_6, HU_7, HU_8, HU_9, HU_0,
        HU_Q, HU_W, HU_E, HU_R, HU_T, HU_Y, HU_U, HU_I, HU_O, HU_P,
        HU_A, HU_S, HU_D, HU_F, HU_G, HU_H, HU_J, HU_K, HU_L, HU_RET,
        HU_LSHIFT, HU_Z, HU_X, HU_C, HU_V, HU_B, HU_N, HU_M, HU_LALT, HU_SPACE
    };

endpackage

`default_nettype wire

// ===== rtl/kmpm_key_state.sv =====
// kmpm_key_state: pressed flag for each host key, updated by key events
// depends on kmpm_pkg
`timescale 1ns / 1ps
`default_nettype none

module kmpm_key_state (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  kmpm_pkg::t_key_event  i_event,
    output kmpm_pkg::t_key_map    o_key_down
);

    kmpm_pkg::t_key_map r_key_down;

    // one flag written per event, all released at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_down <= '0;
        end else if (i_event.we) begin
            r_key_down[i_event.code] <= i_event.down;
        end
    end

    assign o_key_down = r_key_down;

endmodule

`default_nettype wire

// ===== rtl/kmpm_matrix_map.sv =====
// kmpm_matrix_map: maps the host key bitmap onto the 40 matrix keys
// positional and symbolic layouts; depends on kmpm_pkg
`timescale 1ns / 1ps
`default_nettype none

module kmpm_matrix_map (
    input  kmpm_pkg::t_key_map  i_key_down,
    input  wire                 i_layout_mode,
    output kmpm_pkg::t_matrix   o_matrix
);

    kmpm_pkg::t_key_map kd;
    kmpm_pkg::t_matrix  pos;
    kmpm_pkg::t_matrix  sym;

    assign kd = i_key_down;

    // positional layout: direct keys plus right modifiers and combos
    always_comb begin
        for (int i = 0; i < kmpm_pkg::NUM_MKEYS; i++) begin
            pos[i] = kd[kmpm_pkg::DIRECT_CODE[i]];
        end
        pos[kmpm_pkg::MK_CS] = kd[kmpm_pkg::HU_LSHIFT] | kd[kmpm_pkg::HU_RSHIFT]
            | kd[kmpm_pkg::HU_BKSP] | kd[kmpm_pkg::HU_GRAVE] | kd[kmpm_pkg::HU_LEFT]
            | kd[kmpm_pkg::HU_DOWN] | kd[kmpm_pkg::HU_UP] | kd[kmpm_pkg::HU_RIGHT]
            | kd[kmpm_pkg::HU_ESC] | kd[kmpm_pkg::HU_TAB];
        pos[kmpm_pkg::MK_SS] = kd[kmpm_pkg::HU_LALT] | kd[kmpm_pkg::HU_RALT]
            | kd[kmpm_pkg::HU_SEMI] | kd[kmpm_pkg::HU_APOS] | kd[kmpm_pkg::HU_COMMA]
            | kd[kmpm_pkg::HU_PERIOD] | kd[kmpm_pkg::HU_TAB];
        pos[kmpm_pkg::MK_0] = kd[kmpm_pkg::HU_0] | kd[kmpm_pkg::HU_BKSP];
        pos[kmpm_pkg::MK_1] = kd[kmpm_pkg::HU_1] | kd[kmpm_pkg::HU_GRAVE];
        pos[kmpm_pkg::MK_5] = kd[kmpm_pkg::HU_5] | kd[kmpm_pkg::HU_LEFT];
        pos[kmpm_pkg::MK_6] = kd[kmpm_pkg::HU_6] | kd[kmpm_pkg::HU_DOWN];
        pos[kmpm_pkg::MK_7] = kd[kmpm_pkg::HU_7] | kd[kmpm_pkg::HU_UP];
        pos[kmpm_pkg::MK_8] = kd[kmpm_pkg::HU_8] | kd[kmpm_pkg::HU_RIGHT];
        pos[kmpm_pkg::MK_SP] = kd[kmpm_pkg::HU_SPACE] | kd[kmpm_pkg::HU_ESC];
        pos[kmpm_pkg::MK_O] = kd[kmpm_pkg::HU_O] | kd[kmpm_pkg::HU_SEMI];
        pos[kmpm_pkg::MK_P] = kd[kmpm_pkg::HU_P] | kd[kmpm_pkg::HU_APOS];
        pos[kmpm_pkg::MK_N] = kd[kmpm_pkg::HU_N] | kd[kmpm_pkg::HU_COMMA];
        pos[kmpm_pkg::MK_M] = kd[kmpm_pkg::HU_M] | kd[kmpm_pkg::HU_PERIOD];
    end

    // symbolic layout: shift-dependent translation
    logic s;
    logic n;
    logic alt;
    logic any_letter;
    logic any_digit;

    assign s   = kd[kmpm_pkg::HU_LSHIFT] | kd[kmpm_pkg::HU_RSHIFT];
    assign n   = ~s;
    assign alt = kd[kmpm_pkg::HU_LALT] | kd[kmpm_pkg::HU_RALT];
    assign any_letter = |kd[kmpm_pkg::HU_LETTER_HI:kmpm_pkg::HU_LETTER_LO];
    assign any_digit  = (|kd[kmpm_pkg::HU_DIGIT_HI:kmpm_pkg::HU_DIGIT_LO])
        | kd[kmpm_pkg::HU_GRAVE] | kd[kmpm_pkg::HU_NUBSLASH];

    always_comb begin
        sym[kmpm_pkg::MK_1] = kd[kmpm_pkg::HU_1] | (kd[kmpm_pkg::HU_GRAVE] & n);
        sym[kmpm_pkg::MK_2] = kd[kmpm_pkg::HU_2] | kd[kmpm_pkg::HU_CAPS];
        sym[kmpm_pkg::MK_3] = kd[kmpm_pkg::HU_3];
        sym[kmpm_pkg::MK_4] = kd[kmpm_pkg::HU_4];
        sym[kmpm_pkg::MK_5] = kd[kmpm_pkg::HU_5] | (n & kd[kmpm_pkg::HU_LEFT]);
        sym[kmpm_pkg::MK_6] = (n & (kd[kmpm_pkg::HU_6] | kd[kmpm_pkg::HU_DOWN]))
            | (s & kd[kmpm_pkg::HU_7]);
        sym[kmpm_pkg::MK_7] = n & (kd[kmpm_pkg::HU_7] | kd[kmpm_pkg::HU_UP]
            | kd[kmpm_pkg::HU_APOS]);
        sym[kmpm_pkg::MK_8] = (n & (kd[kmpm_pkg::HU_8] | kd[kmpm_pkg::HU_RIGHT]))
            | (s & kd[kmpm_pkg::HU_9]);
        sym[kmpm_pkg::MK_9] = (n & kd[kmpm_pkg::HU_9]) | (s & kd[kmpm_pkg::HU_0]);
        sym[kmpm_pkg::MK_0] = (n & (kd[kmpm_pkg::HU_0] | kd[kmpm_pkg::HU_BKSP]))
            | (s & kd[kmpm_pkg::HU_MINUS]);

        sym[kmpm_pkg::MK_Q] = kd[kmpm_pkg::HU_Q];
        sym[kmpm_pkg::MK_W] = kd[kmpm_pkg::HU_W];
        sym[kmpm_pkg::MK_E] = kd[kmpm_pkg::HU_E];
        sym[kmpm_pkg::MK_R] = kd[kmpm_pkg::HU_R] | (s & kd[kmpm_pkg::HU_COMMA]);
        sym[kmpm_pkg::MK_T] = kd[kmpm_pkg::HU_T] | (s & kd[kmpm_pkg::HU_PERIOD]);
        sym[kmpm_pkg::MK_Y] = kd[kmpm_pkg::HU_Y] | (n & kd[kmpm_pkg::HU_LBRK]);
        sym[kmpm_pkg::MK_U] = kd[kmpm_pkg::HU_U] | (n & kd[kmpm_pkg::HU_RBRK]);
        sym[kmpm_pkg::MK_I] = kd[kmpm_pkg::HU_I];
        sym[kmpm_pkg::MK_O] = kd[kmpm_pkg::HU_O] | (n & kd[kmpm_pkg::HU_SEMI]);
        sym[kmpm_pkg::MK_P] = kd[kmpm_pkg::HU_P] | (s & kd[kmpm_pkg::HU_APOS]);

        sym[kmpm_pkg::MK_A] = kd[kmpm_pkg::HU_A]
            | (s & (kd[kmpm_pkg::HU_GRAVE] | kd[kmpm_pkg::HU_NUBSLASH]));
        sym[kmpm_pkg::MK_S] = kd[kmpm_pkg::HU_S] | (s & kd[kmpm_pkg::HU_BSLASH]);
        sym[kmpm_pkg::MK_D] = kd[kmpm_pkg::HU_D] | (n & kd[kmpm_pkg::HU_BSLASH]);
        sym[kmpm_pkg::MK_F] = kd[kmpm_pkg::HU_F] | (s & kd[kmpm_pkg::HU_LBRK]);
        sym[kmpm_pkg::MK_G] = kd[kmpm_pkg::HU_G] | (s & kd[kmpm_pkg::HU_RBRK]);
        sym[kmpm_pkg::MK_H] = kd[kmpm_pkg::HU_H] | (s & kd[kmpm_pkg::HU_6]);
        sym[kmpm_pkg::MK_J] = kd[kmpm_pkg::HU_J] | (n & kd[kmpm_pkg::HU_MINUS]);
        sym[kmpm_pkg::MK_K] = kd[kmpm_pkg::HU_K] | (s & kd[kmpm_pkg::HU_EQUALS]);
        sym[kmpm_pkg::MK_L] = kd[kmpm_pkg::HU_L] | (n & kd[kmpm_pkg::HU_EQUALS]);
        sym[kmpm_pkg::MK_ENT] = kd[kmpm_pkg::HU_RET];

        sym[kmpm_pkg::MK_CS] = kd[kmpm_pkg::HU_TAB] | kd[kmpm_pkg::HU_CAPS]
            | kd[kmpm_pkg::HU_BKSP] | kd[kmpm_pkg::HU_ESC] | kd[kmpm_pkg::HU_LEFT]
            | kd[kmpm_pkg::HU_RIGHT] | kd[kmpm_pkg::HU_UP] | kd[kmpm_pkg::HU_DOWN]
            | (s & any_letter);
        sym[kmpm_pkg::MK_Z] = kd[kmpm_pkg::HU_Z] | (s & kd[kmpm_pkg::HU_SEMI]);
        sym[kmpm_pkg::MK_X] = kd[kmpm_pkg::HU_X] | (n & alt & kd[kmpm_pkg::HU_2]);
        sym[kmpm_pkg::MK_C] = kd[kmpm_pkg::HU_C] | (s & kd[kmpm_pkg::HU_SLASH]);
        sym[kmpm_pkg::MK_V] = kd[kmpm_pkg::HU_V] | (n & kd[kmpm_pkg::HU_SLASH]);
        sym[kmpm_pkg::MK_B] = kd[kmpm_pkg::HU_B] | (s & kd[kmpm_pkg::HU_8]);
        sym[kmpm_pkg::MK_N] = kd[kmpm_pkg::HU_N] | (n & kd[kmpm_pkg::HU_COMMA]);
        sym[kmpm_pkg::MK_M] = kd[kmpm_pkg::HU_M] | (n & kd[kmpm_pkg::HU_PERIOD]);
        sym[kmpm_pkg::MK_SS] = alt | kd[kmpm_pkg::HU_APOS] | kd[kmpm_pkg::HU_SEMI]
            | kd[kmpm_pkg::HU_MINUS] | kd[kmpm_pkg::HU_EQUALS] | kd[kmpm_pkg::HU_SLASH]
            | kd[kmpm_pkg::HU_COMMA] | kd[kmpm_pkg::HU_PERIOD] | kd[kmpm_pkg::HU_LBRK]
            | kd[kmpm_pkg::HU_RBRK] | kd[kmpm_pkg::HU_BSLASH] | kd[kmpm_pkg::HU_TAB]
            | (s & any_digit);
        sym[kmpm_pkg::MK_SP] = kd[kmpm_pkg::HU_SPACE] | (n & kd[kmpm_pkg::HU_ESC]);
    end

    // layout select
    assign o_matrix = i_layout_mode ? sym : pos;

endmodule

`default_nettype wire

// ===== rtl/kmpm_row_mux.sv =====
// kmpm_row_mux: ORs the selected half-rows and forms the active-low read data
// depends on kmpm_pkg
`timescale 1ns / 1ps
`default_nettype none

module kmpm_row_mux (
    input  kmpm_pkg::t_matrix  i_matrix,
    input  wire [7:0]          i_row_sel,
    output logic [7:0]         o_read_data
);

    logic [kmpm_pkg::HROW_KEYS-1:0] acc;

    // left half-rows run inward from the left end of rows 3..0,
    // right half-rows run inward from the right end of rows 0..3
    always_comb begin
        acc = '0;
        for (int k = 0; k < kmpm_pkg::NUM_HROWS; k++) begin
            for (int j = 0; j < kmpm_pkg::HROW_KEYS; j++) begin
                if (k < 4) begin
                    acc[j] = acc[j] | (i_row_sel[k] & i_matrix[(3 - k) * 10 + j]);
                end else begin
                    acc[j] = acc[j] | (i_row_sel[k] & i_matrix[(k - 4) * 10 + 9 - j]);
                end
            end
        end
    end

    assign o_read_data = {3'b000, ~acc};

endmodule

`default_nettype wire

// ===== rtl/keyboard_matrix_port_mapper_core.sv =====
// keyboard_matrix_port_mapper_core: top level of the keyboard matrix port mapper
// uses kmpm_pkg, kmpm_key_state, kmpm_matrix_map, kmpm_row_mux
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per clock while input ready is high. A key event updates the
// host key bitmap at the edge that accepts it and gives no result. A port read
// is held in an input register while the key map and half-row select logic
// work on it, and its read data is loaded into the result register when that
// register is free or its item is taken. Input ready follows output ready
// combinationally through the two stages; when the result register holds an
// item that is not taken, the input stage fills and then input ready drops.
// Reset clears all keys to released and selects the positional layout.
module keyboard_matrix_port_mapper_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_op,
    input  wire  [7:0]  i_key_code,
    input  wire         i_key_down,
    input  wire  [15:0] i_port_address,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_read_data
);

    logic                  r_layout_mode;
    logic                  r_s1_vld;
    logic                  n_s1_vld;
    logic [7:0]            r_s1_sel;
    logic                  r_out_vld;
    logic                  n_out_vld;
    logic [7:0]            r_read_data;
    logic                  out_free;
    logic                  s1_free;
    logic                  in_acc;
    kmpm_pkg::t_key_event  key_event;
    kmpm_pkg::t_key_map    key_down;
    kmpm_pkg::t_matrix     matrix;
    logic [7:0]            read_data;

    // layout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layout_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_layout_mode <= i_cfg_wdata;
        end
    end

    // handshake
    assign out_free   = !r_out_vld || i_out_ready;
    assign s1_free    = !r_s1_vld || out_free;
    assign o_in_ready = s1_free;
    assign in_acc     = i_in_valid && s1_free;

    // key event toward the bitmap
    assign key_event.we   = in_acc && (i_op == kmpm_pkg::OP_KEY_EVENT);
    assign key_event.code = i_key_code;
    assign key_event.down = i_key_down;

    kmpm_key_state u_key_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_event    (key_event),
        .o_key_down (key_down)
    );

    // input stage for port reads
    always_comb begin
        n_s1_vld = r_s1_vld;
        if (s1_free) begin
            n_s1_vld = in_acc && (i_op == kmpm_pkg::OP_PORT_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= n_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_sel <= ~i_port_address[15:8];
        end
    end

    // mapping from the current bitmap
    kmpm_matrix_map u_matrix_map (
        .i_key_down    (key_down),
        .i_layout_mode (r_layout_mode),
        .o_matrix      (matrix)
    );

    kmpm_row_mux u_row_mux (
        .i_matrix    (matrix),
        .i_row_sel   (r_s1_sel),
        .o_read_data (read_data)
    );

    // result register
    always_comb begin
        n_out_vld = r_out_vld;
        if (out_free) begin
            n_out_vld = r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_vld) begin
            r_read_data <= read_data;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_read_data = r_read_data;

endmodule

`default_nettype wire

// ===== rtl/kmpm_checker.sv =====
// kmpm_checker: port-level checks of the keyboard matrix port mapper
// bound to keyboard_matrix_port_mapper_core; no package use
`timescale 1ns / 1ps
`default_nettype none

module kmpm_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_in_ready,
    input wire         o_out_valid,
    input wire         i_out_ready,
    input wire  [7:0]  o_read_data
);

    // a stalled item holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data))
        else $error("result item changed while stalled");

    // upper bits of the read data are zero whenever a result is valid
    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_read_data[7:5] == 3'b000)
        else $error("read data upper bits not zero");

    // input only backs up behind a stalled result
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input not ready while output free");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind keyboard_matrix_port_mapper_core kmpm_checker u_kmpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_read_data (o_read_data)
);

`default_nettype wire
